### sv/lps_pkg.sv
// ----------------------------------------------------------------------------
// lps_pkg
// Shared types, codes and tables of the LED pattern sequencer.
// ----------------------------------------------------------------------------
package lps_pkg;

    localparam int LED_COUNT   = 16;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_LONG_PRESS  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SHORT_PRESS = 2'd1;

    localparam logic [7:0] LONG_PRESS_RESET  = 8'd48;
    localparam logic [7:0] SHORT_PRESS_RESET = 8'd2;

    localparam logic [1:0] OPT_ANIM   = 2'd0;
    localparam logic [1:0] OPT_SPEED  = 2'd1;
    localparam logic [1:0] OPT_BRIGHT = 2'd2;

    localparam logic [2:0] ANIM_MIRROR = 3'd0;
    localparam logic [2:0] ANIM_BLINK  = 3'd1;
    localparam logic [2:0] ANIM_PAIRS  = 3'd2;
    localparam logic [2:0] ANIM_STAR   = 3'd3;
    localparam logic [2:0] ANIM_FILL   = 3'd4;
    localparam logic [2:0] ANIM_RUN    = 3'd5;

    localparam logic [6:0] PERIOD_STEP  = 7'd12;
    localparam logic [7:0] PERIOD_WRAP  = 8'd120;
    localparam logic [7:0] DUTY_STEP    = 8'd20;
    localparam logic [7:0] DUTY_MAX     = 8'd235;
    localparam logic [7:0] PRESS_MAX    = 8'd255;

    localparam logic [LED_COUNT-1:0] ALL_LEDS = '1;

    typedef struct packed {
        logic [1:0] option;
        logic [2:0] anim_sel;
        logic [6:0] period;
        logic [7:0] duty;
        logic       anim_clear;
    } menu_t;

    function automatic logic [7:0] step_limit(input logic [2:0] sel);
        logic [7:0] lim;
        case (sel)
            ANIM_MIRROR: lim = 8'd12;
            ANIM_BLINK:  lim = 8'd2;
            ANIM_PAIRS:  lim = 8'd12;
            ANIM_STAR:   lim = 8'd6;
            ANIM_FILL:   lim = 8'd0;
            ANIM_RUN:    lim = 8'd20;
            default:     lim = 8'd0;
        endcase
        return lim;
    endfunction

    function automatic logic [LED_COUNT-1:0] led_bit(input logic [3:0] pos);
        return LED_COUNT'(1) << pos;
    endfunction

    function automatic logic [LED_COUNT-1:0] flip_mask(input logic [2:0] sel,
                                                       input logic [7:0] s);
        logic [LED_COUNT-1:0] m;
        logic [3:0]           lo;
        m  = '0;
        lo = s[3:0];
        case (sel)
            ANIM_MIRROR:
            begin
                if (s <= 8'd8)
                begin
                    m = led_bit(lo);
                    if (s != 8'd0 && s != 8'd8)
                        m = m ^ led_bit(4'd0 - lo);
                end
            end
            ANIM_BLINK:
                m = ALL_LEDS;
            ANIM_PAIRS:
            begin
                if (s < 8'd8)
                    m = led_bit(lo) ^ led_bit(lo + 4'd8);
            end
            ANIM_STAR:
            begin
                if (s inside {8'd0, 8'd4})
                    m = led_bit(lo) ^ led_bit(lo + 4'd8);
                else if (s < 8'd4)
                    m = led_bit(lo) ^ led_bit(4'd8 - lo)
                        ^ led_bit(lo + 4'd8) ^ led_bit(4'd0 - lo);
            end
            ANIM_RUN:
            begin
                if (s < 8'd16)
                    m = led_bit(lo);
            end
            default:
                m = '0;
        endcase
        return m;
    endfunction

endpackage

### sv/led_pattern_sequencer_with_button_menu_unit.sv
// ----------------------------------------------------------------------------
// led_pattern_sequencer_with_button_menu_unit
// LED pattern sequencer driven by a single button menu.
// ----------------------------------------------------------------------------
// Each input transaction is one slow tick carrying the button level. Each
// accepted tick yields exactly one output transaction with the LED pattern,
// brightness, menu option, animation number and step period after that tick.
// Ticks are held in an input register and processed on their way into the
// output register, which holds each result until the receiver takes it.
// One tick per cycle is sustained: the press counter, menu and animation
// update are a single shallow step from the input register to the output
// register, and in_ready stays high while the output can be refilled.
// When the receiver stalls, the result holds in the output register and one
// more tick is parked in the input register; in_ready then drops until
// out_ready returns.
// The configuration channel is always ready and sets the long and short
// press thresholds; index values outside the list are ignored. Write it only
// while no tick is in flight.
// Reset clears the valid flags and the menu and animation state: LEDs off,
// option 0, animation 0, period 12, brightness 20, thresholds 48 and 2.
// ----------------------------------------------------------------------------
module led_pattern_sequencer_with_button_menu_unit
    import lps_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]             cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   button_down,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [LED_COUNT-1:0]   led_pattern,
    output logic [7:0]             brightness,
    output logic [1:0]             menu_option,
    output logic [2:0]             animation_index,
    output logic [6:0]             tick_period
);

    logic [7:0]           long_press_reg;
    logic [7:0]           short_press_reg;
    logic                 tick_valid_reg, tick_valid_next;
    logic                 button_reg;
    logic                 out_valid_reg,  out_valid_next;
    logic                 advance;
    menu_t                menu_next;
    logic [LED_COUNT-1:0] pattern_next;
    logic [LED_COUNT-1:0] led_pattern_reg;
    logic [7:0]           brightness_reg;
    logic [1:0]           option_out_reg;
    logic [2:0]           anim_out_reg;
    logic [6:0]           period_out_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_press_reg  <= LONG_PRESS_RESET;
            short_press_reg <= SHORT_PRESS_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_LONG_PRESS:  long_press_reg  <= cfg_data;
                CFG_SHORT_PRESS: short_press_reg <= cfg_data;
                default:         long_press_reg  <= long_press_reg;
            endcase
        end
    end

    assign advance  = tick_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !tick_valid_reg || advance;

    always_comb
    begin
        if (in_valid && in_ready)
            tick_valid_next = 1'b1;
        else if (advance)
            tick_valid_next = 1'b0;
        else
            tick_valid_next = tick_valid_reg;

        if (advance)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            tick_valid_reg <= tick_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            button_reg <= button_down;
    end

    lps_menu u_menu
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .advance           (advance),
        .button_down       (button_reg),
        .long_press_ticks  (long_press_reg),
        .short_press_ticks (short_press_reg),
        .menu_next         (menu_next)
    );

    lps_anim u_anim
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .menu_next    (menu_next),
        .pattern_next (pattern_next)
    );

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            led_pattern_reg <= pattern_next;
            brightness_reg  <= menu_next.duty;
            option_out_reg  <= menu_next.option;
            anim_out_reg    <= menu_next.anim_sel;
            period_out_reg  <= menu_next.period;
        end
    end

    assign out_valid       = out_valid_reg;
    assign led_pattern     = led_pattern_reg;
    assign brightness      = brightness_reg;
    assign menu_option     = option_out_reg;
    assign animation_index = anim_out_reg;
    assign tick_period     = period_out_reg;

    a_option_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> menu_option != 2'd3)
        else $error("menu option out of range");

    a_anim_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> animation_index <= ANIM_RUN)
        else $error("animation index out of range");

    a_period_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (tick_period >= 7'd12 && tick_period <= 7'd108))
        else $error("tick period out of range");

    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (brightness >= 8'd20 && brightness <= 8'd240))
        else $error("brightness out of range");

    a_stall_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_valid_reg && out_valid && !out_ready) |-> !in_ready)
        else $error("tick taken while both stages full");

endmodule

### sv/lps_menu.sv
// ----------------------------------------------------------------------------
// lps_menu
// Button press counter and menu: option, animation, speed and brightness.
// ----------------------------------------------------------------------------
module lps_menu
    import lps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  logic        button_down,
    input  logic [7:0]  long_press_ticks,
    input  logic [7:0]  short_press_ticks,
    output menu_t       menu_next
);

    logic [7:0] press_count_reg, press_count_next;
    logic [1:0] option_reg,      option_next;
    logic [2:0] anim_sel_reg,    anim_sel_next;
    logic [6:0] period_reg,      period_next;
    logic [7:0] duty_reg,        duty_next;
    logic       clear_next;
    logic [7:0] period_sum;

    always_comb
    begin
        press_count_next = press_count_reg;
        option_next      = option_reg;
        anim_sel_next    = anim_sel_reg;
        period_next      = period_reg;
        duty_next        = duty_reg;
        clear_next       = 1'b0;
        period_sum       = {1'b0, period_reg} + {1'b0, PERIOD_STEP};
        if (button_down)
        begin
            if (press_count_reg != PRESS_MAX)
                press_count_next = press_count_reg + 8'd1;
        end
        else
        begin
            press_count_next = '0;
            if (press_count_reg > long_press_ticks)
            begin
                option_next = (option_reg >= OPT_BRIGHT) ? OPT_ANIM : option_reg + 2'd1;
            end
            else if (press_count_reg > short_press_ticks)
            begin
                case (option_reg)
                    OPT_ANIM:
                    begin
                        anim_sel_next = (anim_sel_reg >= ANIM_RUN) ? ANIM_MIRROR
                                                                   : anim_sel_reg + 3'd1;
                        clear_next    = 1'b1;
                    end
                    OPT_SPEED:
                        period_next = (period_sum >= PERIOD_WRAP) ? PERIOD_STEP
                                                                  : period_sum[6:0];
                    OPT_BRIGHT:
                        duty_next = (duty_reg > DUTY_MAX) ? DUTY_STEP : duty_reg + DUTY_STEP;
                    default:
                        duty_next = duty_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_count_reg <= '0;
            option_reg      <= OPT_ANIM;
            anim_sel_reg    <= ANIM_MIRROR;
            period_reg      <= PERIOD_STEP;
            duty_reg        <= DUTY_STEP;
        end
        else if (advance)
        begin
            press_count_reg <= press_count_next;
            option_reg      <= option_next;
            anim_sel_reg    <= anim_sel_next;
            period_reg      <= period_next;
            duty_reg        <= duty_next;
        end
    end

    assign menu_next = '{option:     option_next,
                         anim_sel:   anim_sel_next,
                         period:     period_next,
                         duty:       duty_next,
                         anim_clear: clear_next};

endmodule

### sv/lps_anim.sv
// ----------------------------------------------------------------------------
// lps_anim
// Tick divider, animation step counter and LED pattern update.
// ----------------------------------------------------------------------------
module lps_anim
    import lps_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  menu_t                menu_next,
    output logic [LED_COUNT-1:0] pattern_next
);

    logic [6:0]           divider_reg, divider_next;
    logic [7:0]           step_reg,    step_next;
    logic [LED_COUNT-1:0] pattern_reg;
    logic [7:0]           step_base;
    logic [7:0]           step_inc;
    logic [LED_COUNT-1:0] pattern_base;
    logic [7:0]           div_inc;

    always_comb
    begin
        step_base    = menu_next.anim_clear ? 8'd0 : step_reg;
        pattern_base = menu_next.anim_clear ? '0 : pattern_reg;
        div_inc      = {1'b0, divider_reg} + 8'd1;
        step_inc     = step_base + 8'd1;
        divider_next = div_inc[6:0];
        step_next    = step_base;
        pattern_next = pattern_base;
        if (div_inc >= {1'b0, menu_next.period})
        begin
            divider_next = '0;
            if (menu_next.anim_sel == ANIM_FILL)
                pattern_next = pattern_base | ALL_LEDS;
            else
                pattern_next = pattern_base ^ flip_mask(menu_next.anim_sel, step_base);
            step_next = (step_inc == step_limit(menu_next.anim_sel)) ? 8'd0 : step_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            divider_reg <= '0;
            step_reg    <= '0;
            pattern_reg <= '0;
        end
        else if (advance)
        begin
            divider_reg <= divider_next;
            step_reg    <= step_next;
            pattern_reg <= pattern_next;
        end
    end

endmodule

### test/led_pattern_sequencer_with_button_menu_unit_tb.sv
// ----------------------------------------------------------------------------
// led_pattern_sequencer_with_button_menu_unit_tb
// Self-checking bench for the button menu LED pattern sequencer.
// ----------------------------------------------------------------------------
// Ticks carrying the button level are sent over the input channel in bursts
// with random gaps, while the result channel stalls on its own pattern. A
// tick-level predictor of the press counter, menu, divider and animations
// builds the expected result of every accepted tick, and a monitor compares
// each result transaction, field by field, with the oldest one outstanding.
// Directed tests cover reset state, the short press boundary, thresholds at
// their extremes, a saturating hold and backpressure; random phases then run
// well-formed press sequences with noise under several threshold settings.
// ----------------------------------------------------------------------------
module led_pattern_sequencer_with_button_menu_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lps_pkg::*;

    localparam int                      CYCLE_LIMIT  = 200000;
    localparam int                      HOLD_CYCLES  = 80;
    localparam logic [CFG_INDEX_W-1:0]  CFG_SPARE    = 2'd3;
    localparam logic [6:0]              PERIOD_FIRST = 7'd12;
    localparam int                      PERIOD_INC   = 12;
    localparam int                      PERIOD_END   = 120;
    localparam logic [7:0]              DUTY_FIRST   = 8'd20;
    localparam logic [7:0]              DUTY_INC     = 8'd20;
    localparam logic [7:0]              DUTY_TOP     = 8'd235;
    localparam logic [7:0]              PRESS_SAT    = 8'hFF;

    typedef struct packed {
        logic [LED_COUNT-1:0] leds;
        logic [7:0]           duty;
        logic [1:0]           option;
        logic [2:0]           anim;
        logic [6:0]           period;
    } lamp_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [7:0]             cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic                   button_down = 1'b0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [LED_COUNT-1:0]   led_pattern;
    logic [7:0]             brightness;
    logic [1:0]             menu_option;
    logic [2:0]             animation_index;
    logic [6:0]             tick_period;

    lamp_t pending_lamps[$];

    logic [7:0]           long_limit  = LONG_PRESS_RESET;
    logic [7:0]           short_limit = SHORT_PRESS_RESET;
    logic [7:0]           press_ticks = '0;
    logic [1:0]           menu_sel    = OPT_ANIM;
    logic [2:0]           anim_now    = ANIM_MIRROR;
    logic [7:0]           anim_pos    = '0;
    logic [6:0]           div_count   = '0;
    logic [6:0]           period_now  = PERIOD_FIRST;
    logic [7:0]           duty_now    = DUTY_FIRST;
    logic [LED_COUNT-1:0] leds_now    = '0;

    int  ticks_sent      = 0;
    int  results_checked = 0;
    int  mismatches      = 0;
    int  cycle_count     = 0;
    int  burst_left      = 0;
    bit  hold_request    = 1'b0;
    int  hold_left       = 0;
    int  window_left     = 0;
    int  ready_mode      = 0;

    led_pattern_sequencer_with_button_menu_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .button_down     (button_down),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .led_pattern     (led_pattern),
        .brightness      (brightness),
        .menu_option     (menu_option),
        .animation_index (animation_index),
        .tick_period     (tick_period)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic logic [7:0] steps_in_cycle(input logic [2:0] sel);
        case (sel)
            ANIM_MIRROR: return 8'd12;
            ANIM_BLINK:  return 8'd2;
            ANIM_PAIRS:  return 8'd12;
            ANIM_STAR:   return 8'd6;
            ANIM_RUN:    return 8'd20;
            default:     return 8'd0;
        endcase
    endfunction

    function automatic logic [LED_COUNT-1:0] toggle_mask(input logic [2:0] sel,
                                                         input logic [7:0] s);
        logic [LED_COUNT-1:0] m;
        int                   k;
        m = '0;
        k = int'(s);
        case (sel)
            ANIM_MIRROR:
            begin
                if (k <= 8)
                begin
                    m[k] = 1'b1;
                    if (k != 0 && k != 8)
                        m[16 - k] = 1'b1;
                end
            end
            ANIM_BLINK:
                m = '1;
            ANIM_PAIRS:
            begin
                if (k < 8)
                begin
                    m[k]     = 1'b1;
                    m[k + 8] = 1'b1;
                end
            end
            ANIM_STAR:
            begin
                if (k == 0 || k == 4)
                begin
                    m[k]     = 1'b1;
                    m[k + 8] = 1'b1;
                end
                else if (k < 4)
                begin
                    m[k]      = 1'b1;
                    m[8 - k]  = 1'b1;
                    m[k + 8]  = 1'b1;
                    m[16 - k] = 1'b1;
                end
            end
            ANIM_RUN:
            begin
                if (k < 16)
                    m[k] = 1'b1;
            end
            default:
                m = '0;
        endcase
        return m;
    endfunction

    task automatic apply_short_press();
        int p;
        if (menu_sel == OPT_ANIM)
        begin
            anim_now = (anim_now >= ANIM_RUN) ? ANIM_MIRROR : anim_now + 3'd1;
            anim_pos = '0;
            leds_now = '0;
        end
        else if (menu_sel == OPT_SPEED)
        begin
            p = int'(period_now) + PERIOD_INC;
            period_now = (p >= PERIOD_END) ? PERIOD_FIRST : 7'(p);
        end
        else if (menu_sel == OPT_BRIGHT)
            duty_now = (duty_now > DUTY_TOP) ? DUTY_FIRST : duty_now + DUTY_INC;
    endtask

    task automatic advance_lamps(input logic down);
        int d;
        if (down)
        begin
            if (press_ticks != PRESS_SAT)
                press_ticks++;
        end
        else
        begin
            if (press_ticks > long_limit)
                menu_sel = (menu_sel >= OPT_BRIGHT) ? OPT_ANIM : menu_sel + 2'd1;
            else if (press_ticks > short_limit)
                apply_short_press();
            press_ticks = '0;
        end
        d = int'(div_count) + 1;
        if (d >= int'(period_now))
        begin
            div_count = '0;
            leds_now  = leds_now ^ toggle_mask(anim_now, anim_pos);
            if (anim_now == ANIM_FILL)
                leds_now = '1;
            anim_pos = anim_pos + 8'd1;
            if (anim_pos == steps_in_cycle(anim_now))
                anim_pos = '0;
        end
        else
            div_count = 7'(d);
        pending_lamps.push_back('{leds_now, duty_now, menu_sel, anim_now, period_now});
    endtask

    always @(posedge clk)
    begin
        lamp_t want;
        lamp_t got;
        if (rst_n && out_valid && out_ready)
        begin
            results_checked++;
            got = '{led_pattern, brightness, menu_option, animation_index, tick_period};
            if (pending_lamps.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $write("unexpected result transaction: ");
                    $display("leds %h duty %0d opt %0d anim %0d per %0d",
                             got.leds, got.duty, got.option, got.anim, got.period);
                end
            end
            else
            begin
                want = pending_lamps.pop_front();
                if (got.leds != want.leds || got.duty != want.duty
                    || got.option != want.option || got.anim != want.anim
                    || got.period != want.period)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $write("mismatch at result %0d: ", results_checked);
                        $write("exp leds %h duty %0d opt %0d anim %0d per %0d, ",
                               want.leds, want.duty, want.option, want.anim,
                               want.period);
                        $display("got leds %h duty %0d opt %0d anim %0d per %0d",
                                 got.leds, got.duty, got.option, got.anim,
                                 got.period);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            if (window_left == 0)
            begin
                window_left = $urandom_range(8, 80);
                ready_mode  = $urandom_range(0, 3);
            end
            window_left--;
            case (ready_mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= 1'($urandom_range(0, 1));
                2:       out_ready <= ($urandom_range(0, 3) != 0);
                default: out_ready <= (window_left % 3 != 0);
            endcase
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, pending_lamps.size());
        $display("FAILURE");
        $finish;
    end

    task automatic idle_sender(input int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic send_tick(input logic down);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 32);
            if ($urandom_range(0, 3) != 0)
                idle_sender($urandom_range(1, 6));
        end
        in_valid    <= 1'b1;
        button_down <= down;
        do @(posedge clk); while (!in_ready);
        advance_lamps(down);
        ticks_sent++;
    endtask

    task automatic press(input int len);
        repeat (len) send_tick(1'b1);
        send_tick(1'b0);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_lamps.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_LONG_PRESS)
            long_limit = data;
        else if (idx == CFG_SHORT_PRESS)
            short_limit = data;
        @(posedge clk);
    endtask

    task automatic test_reset_state();
        repeat (4) send_tick(1'b0);
    endtask

    task automatic test_short_press_boundary();
        press(3);
        press(2);
        repeat (3) send_tick(1'b0);
    endtask

    task automatic test_threshold_extremes();
        wait_idle();
        write_reg(CFG_LONG_PRESS, 8'd0);
        write_reg(CFG_SHORT_PRESS, 8'd0);
        press(0);
        press(1);
        wait_idle();
        write_reg(CFG_LONG_PRESS, 8'd255);
        write_reg(CFG_SHORT_PRESS, 8'd255);
        press(4);
        wait_idle();
        write_reg(CFG_SPARE, 8'd0);
        press(3);
    endtask

    task automatic test_press_saturation();
        wait_idle();
        write_reg(CFG_LONG_PRESS, 8'd254);
        write_reg(CFG_SHORT_PRESS, 8'd0);
        press(260);
        repeat (2) send_tick(1'b0);
    endtask

    task automatic test_backpressure();
        wait_idle();
        hold_request = 1'b1;
        repeat (30) send_tick(1'($urandom_range(0, 1)));
        send_tick(1'b0);
        wait_idle();
    endtask

    task automatic run_press_mix(input logic [7:0] long_v, input logic [7:0] short_v,
                                 input int budget);
        int first;
        int kind;
        int top;
        wait_idle();
        write_reg(CFG_LONG_PRESS, long_v);
        write_reg(CFG_SHORT_PRESS, short_v);
        first = ticks_sent;
        while (ticks_sent - first < budget)
        begin
            kind = $urandom_range(0, 19);
            top  = (long_limit > 8'd247) ? 255 : int'(long_limit) + 8;
            if (kind < 11 && short_limit < long_limit)
                press($urandom_range(int'(short_limit) + 1, int'(long_limit)));
            else if (kind < 14 && long_limit != PRESS_SAT)
                press($urandom_range(int'(long_limit) + 1, top));
            else if (kind < 16)
                press($urandom_range(0, int'(short_limit)));
            else if (kind < 18)
                repeat ($urandom_range(1, 6)) send_tick(1'($urandom_range(0, 1)));
            else
                repeat ($urandom_range(1, 12)) send_tick(1'b0);
        end
        send_tick(1'b0);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_short_press_boundary();
        test_threshold_extremes();
        test_press_saturation();
        test_backpressure();
        run_press_mix(8'd1, 8'd0, 80);
        run_press_mix(8'd6, 8'd2, 60);
        run_press_mix(LONG_PRESS_RESET, SHORT_PRESS_RESET, 70);

        wait_idle();
        repeat (8) @(posedge clk);
        $display("Covered %0d ticks: short, long, ignored and saturating presses, all menu options",
                 ticks_sent);
        $display("and threshold extremes; %0d results checked, %0d mismatches",
                 results_checked, mismatches);
        if (mismatches == 0 && pending_lamps.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
